FILE: rtl/mflcr_pkg.sv
// Shared constants for the monochrome frame line/circle raster engine.
// No dependencies.
package mflcr_pkg;
   localparam int OPCODE_W  = 2;
   localparam int COORD_W   = 8;
   localparam int RADIUS_W  = 7;
   localparam int INDEX_W   = 10;
   localparam int BYTE_W    = 8;
   localparam int PAGE_ROWS = 8;

   localparam logic [OPCODE_W-1:0] OP_PIXEL  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LINE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CIRCLE = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd3;
endpackage

FILE: rtl/mflcr_if.sv
// Valid/ready channel interfaces for requests and read responses.
// Depends on mflcr_pkg.
interface mflcr_req_if;
   import mflcr_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [COORD_W-1:0]  x_first;
   logic [COORD_W-1:0]  y_first;
   logic [COORD_W-1:0]  x_second;
   logic [COORD_W-1:0]  y_second;
   logic [RADIUS_W-1:0] radius;
   logic [INDEX_W-1:0]  read_index;
   modport source (output valid, opcode, x_first, y_first, x_second, y_second, radius,
                   read_index, input ready);
   modport sink (input valid, opcode, x_first, y_first, x_second, y_second, radius,
                 read_index, output ready);
endinterface

interface mflcr_rsp_if;
   import mflcr_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_data;
   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

FILE: rtl/mono_frame_line_circle_raster.sv
// Drawing engine for a paged monochrome frame store (FRAME_WIDTH x FRAME_HEIGHT, 8 rows
// per byte, low bit on top). Requests set a pixel, draw a Bresenham line, draw a midpoint
// circle or read one byte; only reads produce a response. Pixels go through a one-per-cycle
// read-modify-write pipeline on the frame RAM; a circle plots four mirrored points per
// step along one quadrant arc. A read goes through the p1 stage and the registered RAM
// read beside p2, then waits in the response register until it is taken. Only one read
// is in flight: another read waits until the response is taken. The RAM port is the
// limit for drawing. After reset a clearing pass writes zero to every one of the
// ((FRAME_HEIGHT+7)/8)*FRAME_WIDTH bytes (1024 by default), one per cycle, before the
// first request.
module mono_frame_line_circle_raster #(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   mflcr_req_if.sink   req_ch,
   mflcr_rsp_if.source rsp_ch
);
   import mflcr_pkg::*;

   localparam int PAGES = (FRAME_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int DEPTH = PAGES * FRAME_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int AM    = AW + 1;
   localparam int CW    = $clog2(FRAME_WIDTH);
   localparam int RW    = $clog2(FRAME_HEIGHT);
   localparam int IW    = (AW > INDEX_W) ? AW : INDEX_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
   localparam int EW = 12;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_PIXEL  = 3'd2;
   localparam logic [2:0] ST_LINE   = 3'd3;
   localparam logic [2:0] ST_CIRCLE = 3'd4;

   // coordinate wrap tables
   logic [CW-1:0] col_lut [256];
   logic [RW-1:0] row_lut [256];
   for (genvar i = 0; i < 256; i++) begin : g_lut
      assign col_lut[i] = CW'(i % FRAME_WIDTH);
      assign row_lut[i] = RW'(i % FRAME_HEIGHT);
   end

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [COORD_W-1:0]  ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [EW-1:0] ldx_ff, ldx_in, ldy_ff, ldy_in, err_ff, err_in;
   logic                sx_ff, sx_in, sy_ff, sy_in;
   logic signed [COORD_W-1:0] cxs_ff, cxs_in;   // circle x, runs -r..0
   logic [COORD_W-1:0]  cys_ff, cys_in;          // circle y, runs 0..r
   logic [1:0]          quad_ff, quad_in;

   logic                p1_valid_ff, p1_rd_ff, p1_oob_ff;
   logic [AW-1:0]       p1_addr_ff;
   logic [2:0]          p1_bit_ff;
   logic                p2_valid_ff, p2_rd_ff, p2_oob_ff;
   logic [AW-1:0]       p2_addr_ff;
   logic [2:0]          p2_bit_ff;
   logic                lw_valid_ff;
   logic [AW-1:0]       lw_addr_ff;
   logic [BYTE_W-1:0]   lw_data_ff;
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   rsp_data_ff;

   logic                accept, gen_valid, rd_issue, rd_busy;
   logic [COORD_W-1:0]  gen_x, gen_y;
   logic [CW-1:0]       col_v;
   logic [RW-1:0]       row_v;
   logic [AW-1:0]       pix_addr;
   logic [IW-1:0]       idx_ext;
   logic [BYTE_W-1:0]   ram_rdata, base, wdata;
   logic                ram_we, p2_write;
   logic [AW-1:0]       ram_waddr;
   logic [BYTE_W-1:0]   ram_wdata;

   logic signed [EW:0]  twice;
   logic signed [EW-1:0] err_a, err_b;
   logic [COORD_W-1:0]  cy_a;
   logic signed [COORD_W-1:0] cx_a;
   logic signed [EW-1:0] y_a_ext, x_a_ext;

   assign rd_busy = rsp_valid_ff || (p1_valid_ff && p1_rd_ff) || (p2_valid_ff && p2_rd_ff);
   assign req_ch.ready = (state_ff == ST_IDLE) && (req_ch.opcode != OP_READ || !rd_busy);
   assign accept = req_ch.valid && req_ch.ready;
   assign rd_issue = accept && req_ch.opcode == OP_READ;

   // line step terms
   assign twice = {err_ff, 1'b0};
   always_comb begin
      err_a = err_ff;
      if (twice >= (EW+1)'(ldy_ff)) begin
         err_a = err_a + ldy_ff;
      end
      if (twice <= (EW+1)'(ldx_ff)) begin
         err_a = err_a + ldx_ff;
      end
   end

   // circle step terms
   always_comb begin
      cy_a = cys_ff;
      err_b = err_ff;
      if (err_ff <= EW'($signed({1'b0, cys_ff}))) begin
         cy_a = cys_ff + 8'd1;
         err_b = err_ff + EW'($signed({1'b0, cy_a, 1'b1}));
      end
      y_a_ext = EW'($signed({1'b0, cy_a}));
      x_a_ext = EW'(cxs_ff);
      cx_a = cxs_ff;
      if (err_ff > x_a_ext || err_b > y_a_ext) begin
         cx_a = cxs_ff + 8'sd1;
         err_b = err_b + EW'(cx_a) + EW'(cx_a) + EW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff; by_in = by_ff;
      ldx_in = ldx_ff; ldy_in = ldy_ff; err_in = err_ff;
      sx_in = sx_ff; sy_in = sy_ff;
      cxs_in = cxs_ff; cys_in = cys_ff; quad_in = quad_ff;
      gen_valid = 1'b0;
      gen_x = ax_ff;
      gen_y = ay_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               ax_in = req_ch.x_first;
               ay_in = req_ch.y_first;
               bx_in = req_ch.x_second;
               by_in = req_ch.y_second;
               sx_in = req_ch.x_first < req_ch.x_second;
               sy_in = req_ch.y_first < req_ch.y_second;
               ldx_in = (req_ch.x_second > req_ch.x_first)
                        ? EW'(req_ch.x_second - req_ch.x_first)
                        : EW'(req_ch.x_first - req_ch.x_second);
               ldy_in = -((req_ch.y_second > req_ch.y_first)
                        ? EW'(req_ch.y_second - req_ch.y_first)
                        : EW'(req_ch.y_first - req_ch.y_second));
               err_in = ldx_in + ldy_in;
               cxs_in = -$signed({1'b0, req_ch.radius});
               cys_in = '0;
               quad_in = 2'd0;
               unique case (req_ch.opcode)
                  OP_PIXEL:  state_in = ST_PIXEL;
                  OP_LINE:   state_in = ST_LINE;
                  OP_CIRCLE: begin
                     state_in = ST_CIRCLE;
                     err_in = EW'(2) - EW'({req_ch.radius, 1'b0});
                  end
                  OP_READ:   state_in = ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIXEL: begin
            gen_valid = 1'b1;
            state_in = ST_IDLE;
         end
         ST_LINE: begin
            gen_valid = 1'b1;
            if (ax_ff == bx_ff && ay_ff == by_ff) begin
               state_in = ST_IDLE;
            end else begin
               err_in = err_a;
               if (twice >= (EW+1)'(ldy_ff)) begin
                  ax_in = sx_ff ? ax_ff + 8'd1 : ax_ff - 8'd1;
               end
               if (twice <= (EW+1)'(ldx_ff)) begin
                  ay_in = sy_ff ? ay_ff + 8'd1 : ay_ff - 8'd1;
               end
            end
         end
         ST_CIRCLE: begin
            gen_valid = 1'b1;
            // ax/ay hold the center
            unique case (quad_ff)
               2'd0: begin gen_x = ax_ff - cxs_ff; gen_y = ay_ff + cys_ff; end
               2'd1: begin gen_x = ax_ff - cys_ff; gen_y = ay_ff - cxs_ff; end
               2'd2: begin gen_x = ax_ff + cxs_ff; gen_y = ay_ff - cys_ff; end
               default: begin gen_x = ax_ff + cys_ff; gen_y = ay_ff + cxs_ff; end
            endcase
            quad_in = quad_ff + 2'd1;
            if (quad_ff == 2'd3) begin
               cys_in = cy_a;
               cxs_in = cx_a;
               err_in = err_b;
               if (!cx_a[COORD_W-1]) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign col_v = col_lut[gen_x];
   assign row_v = row_lut[gen_y];
   assign pix_addr = AW'(AM'(row_v >> 3) * AM'(FRAME_WIDTH) + AM'(col_v));
   assign idx_ext = IW'(req_ch.read_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         p1_valid_ff <= gen_valid || rd_issue;
         p2_valid_ff <= p1_valid_ff;
         lw_valid_ff <= p2_write;
         if (p2_valid_ff && p2_rd_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in; ay_ff <= ay_in; bx_ff <= bx_in; by_ff <= by_in;
      ldx_ff <= ldx_in; ldy_ff <= ldy_in; err_ff <= err_in;
      sx_ff <= sx_in; sy_ff <= sy_in;
      cxs_ff <= cxs_in; cys_ff <= cys_in; quad_ff <= quad_in;
      p1_rd_ff <= rd_issue;
      p1_oob_ff <= rd_issue && idx_ext > LAST_IDX;
      p1_addr_ff <= rd_issue ? AW'(idx_ext) : pix_addr;
      p1_bit_ff <= row_v[2:0];
      p2_rd_ff <= p1_rd_ff;
      p2_oob_ff <= p1_oob_ff;
      p2_addr_ff <= p1_addr_ff;
      p2_bit_ff <= p1_bit_ff;
      lw_addr_ff <= p2_addr_ff;
      lw_data_ff <= wdata;
      if (p2_valid_ff && p2_rd_ff) begin
         rsp_data_ff <= p2_oob_ff ? '0 : base;
      end
   end

   // the RAM read misses a write landing in the same cycle: forward it
   assign base = (lw_valid_ff && lw_addr_ff == p2_addr_ff) ? lw_data_ff : ram_rdata;
   assign wdata = base | (BYTE_W'(1) << p2_bit_ff);
   assign p2_write = p2_valid_ff && !p2_rd_ff;
   assign ram_we = (state_ff == ST_CLEAR) || p2_write;
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_ff : p2_addr_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : wdata;

   mflcr_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_frame (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (p1_valid_ff),
      .raddr (p1_addr_ff),
      .rdata (ram_rdata)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !accept) else $error("request taken during clear");
   a_pipe_empty_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !p1_valid_ff && !p2_valid_ff)
      else $error("pixel traffic during clear");
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(p2_valid_ff && p2_rd_ff))
      else $error("response without read");
   a_one_read_in_flight: assert property (@(posedge clock) disable iff (reset)
      $countones({rsp_valid_ff, p1_valid_ff && p1_rd_ff, p2_valid_ff && p2_rd_ff}) <= 1)
      else $error("overlapping reads");
`endif
endmodule

FILE: rtl/mflcr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on a same-address collision. No dependencies.
module mflcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: dv/mflcr_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side note: the request and response channel interfaces come from rtl/mflcr_if.sv.
// This file holds the scoreboard class used by the testbench top. Depends on mflcr_pkg.
package mflcr_tb_pkg;
   import mflcr_pkg::*;

   class frame_scoreboard;
      localparam int FW = 128;
      localparam int FH = 64;
      localparam int NBYTES = ((FH + 7) / 8) * FW;
      logic [7:0] frame_bytes [NBYTES];
      logic [7:0] read_queue [$];
      int         mismatches;
      int         checked;

      function void clear_frame();
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         read_queue.delete();
      endfunction

      function void plot(int px, int py);
         int col;
         int row;
         col = (px & 255) % FW;
         row = (py & 255) % FH;
         frame_bytes[(row / 8) * FW + col] |= 8'(1 << (row % 8));
      endfunction

      function void trace_line(int ax, int ay, int bx, int by);
         int dx;
         int dy;
         int sx;
         int sy;
         int err;
         int twice;
         dx = bx > ax ? bx - ax : ax - bx;
         dy = -(by > ay ? by - ay : ay - by);
         sx = ax < bx ? 1 : -1;
         sy = ay < by ? 1 : -1;
         err = dx + dy;
         forever begin
            plot(ax, ay);
            if (ax == bx && ay == by) break;
            twice = 2 * err;
            if (twice >= dy) begin
               err += dy;
               ax += sx;
            end
            if (twice <= dx) begin
               err += dx;
               ay += sy;
            end
         end
      endfunction

      function void trace_circle(int cx, int cy, int rad);
         int x;
         int y;
         int err;
         int prev;
         x = -rad;
         y = 0;
         err = 2 - 2 * rad;
         do begin
            plot(cx - x, cy + y);
            plot(cx - y, cy - x);
            plot(cx + x, cy - y);
            plot(cx + y, cy + x);
            prev = err;
            if (prev <= y) begin
               y++;
               err += y * 2 + 1;
            end
            if (prev > x || err > y) begin
               x++;
               err += x * 2 + 1;
            end
         end while (x < 0);
      endfunction

      function void note_request(logic [1:0] op, logic [7:0] xa, logic [7:0] ya,
                                 logic [7:0] xb, logic [7:0] yb, logic [6:0] rad,
                                 logic [9:0] idx);
         case (op)
            OP_PIXEL:  plot(int'(xa), int'(ya));
            OP_LINE:   trace_line(int'(xa), int'(ya), int'(xb), int'(yb));
            OP_CIRCLE: trace_circle(int'(xa), int'(ya), int'(rad));
            default:   read_queue.push_back(int'(idx) < NBYTES ? frame_bytes[idx] : 8'h00);
         endcase
      endfunction

      function void check_read(logic [7:0] got);
         logic [7:0] want;
         checked++;
         if (read_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: read_data=%02h", got);
            return;
         end
         want = read_queue.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("read_data mismatch: expected %02h actual %02h", want, got);
         end
      endfunction
   endclass
endpackage

FILE: dv/mono_frame_line_circle_raster_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for mono_frame_line_circle_raster: random and directed draw/read requests,
// checked against a frame model in mflcr_tb_pkg. Depends on mflcr_pkg, mflcr_tb_pkg and rtl/mflcr_if.sv.
module mono_frame_line_circle_raster_tb;
   import mflcr_pkg::*;
   import mflcr_tb_pkg::*;

   localparam int WATCHDOG = 40000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   mflcr_req_if req_ch ();
   mflcr_rsp_if rsp_ch ();

   mono_frame_line_circle_raster u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   frame_scoreboard frame_sb = new();
   int  sent;
   int  reads_sent;
   int  idle_cycles;
   bit  quiet_tail;
   bit  hold_rsp;
   bit  timed_out;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_PIXEL;
      req_ch.x_first = '0;
      req_ch.y_first = '0;
      req_ch.x_second = '0;
      req_ch.y_second = '0;
      req_ch.radius = '0;
      req_ch.read_index = '0;
      rsp_ch.ready = 1'b0;
   end

   // Accepted requests go to the frame model; responses are checked as they arrive.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            frame_sb.note_request(req_ch.opcode, req_ch.x_first, req_ch.y_first,
                                  req_ch.x_second, req_ch.y_second, req_ch.radius,
                                  req_ch.read_index);
         if (rsp_ch.valid && rsp_ch.ready) frame_sb.check_read(rsp_ch.read_data);
      end
   end

   // Watchdog on cycles without any handshake (long while reset clears the frame).
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: random stall bursts, one long hold-off on request.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_req(logic [1:0] op, logic [7:0] xa, logic [7:0] ya, logic [7:0] xb,
                           logic [7:0] yb, logic [6:0] rad, logic [9:0] idx);
      int gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.x_first <= xa;
      req_ch.y_first <= ya;
      req_ch.x_second <= xb;
      req_ch.y_second <= yb;
      req_ch.radius <= rad;
      req_ch.read_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
      if (op == OP_READ) reads_sent++;
   endtask

   task automatic send_random();
      logic [1:0] op;
      logic [6:0] rad;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_READ;
      else if (pick < 55) op = OP_PIXEL;
      else if (pick < 85) op = OP_LINE;
      else op = OP_CIRCLE;
      // mostly small shapes, occasionally a big one
      rad = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 24));
      send_req(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), rad,
               10'($urandom));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (frame_sb.read_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      sent = 0;
      reads_sent = 0;
      frame_sb.mismatches = 0;
      frame_sb.checked = 0;
      frame_sb.clear_frame();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, wraps, all ops, zero radius, biggest circle, reads back
      send_req(OP_READ, '0, '0, '0, '0, '0, 10'd0);
      send_req(OP_PIXEL, 8'd0, 8'd0, 8'hff, 8'hff, 7'h7f, 10'h3ff);
      send_req(OP_PIXEL, 8'd255, 8'd255, '0, '0, '0, '0);
      send_req(OP_PIXEL, 8'd127, 8'd63, '0, '0, '0, '0);
      send_req(OP_PIXEL, 8'd128, 8'd64, '0, '0, '0, '0);
      send_req(OP_READ, '0, '0, '0, '0, '0, 10'd0);
      send_req(OP_READ, '0, '0, '0, '0, '0, 10'h3ff);
      send_req(OP_LINE, 8'd0, 8'd0, 8'd255, 8'd255, '0, '0);
      send_req(OP_LINE, 8'd200, 8'd10, 8'd3, 8'd250, '0, '0);
      send_req(OP_LINE, 8'd5, 8'd5, 8'd5, 8'd5, '0, '0);
      send_req(OP_LINE, 8'd0, 8'd30, 8'd255, 8'd30, '0, '0);
      send_req(OP_LINE, 8'd70, 8'd255, 8'd70, 8'd0, '0, '0);
      send_req(OP_CIRCLE, 8'd40, 8'd20, '0, '0, 7'd0, '0);
      send_req(OP_CIRCLE, 8'd2, 8'd1, '0, '0, 7'd10, '0);
      send_req(OP_CIRCLE, 8'd255, 8'd255, '0, '0, 7'd127, '0);
      send_req(OP_CIRCLE, 8'd64, 8'd32, '0, '0, 7'd1, '0);
      for (int i = 0; i < 8; i++) send_req(OP_READ, '0, '0, '0, '0, '0, 10'(i * 129 + 1));
      drain();

      // receiver holds off while reads keep coming, so the block backs up
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++) send_req(OP_READ, '0, '0, '0, '0, '0, 10'($urandom));
      for (int i = 0; i < 340; i++) send_random();
      drain();
      for (int i = 0; i < 330; i++) send_random();
      quiet_tail = 1'b1;
      for (int i = 0; i < 120; i++) send_random();
      drain();
      repeat (50) @(posedge clock);

      $display("covered %0d requests (%0d reads, %0d responses checked), all opcodes, wrap",
               sent, reads_sent, frame_sb.checked);
      $display("and extreme radii, with random stalls on both channels and one long hold-off");
      if (frame_sb.mismatches == 0 && frame_sb.read_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", frame_sb.mismatches,
                  frame_sb.read_queue.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/mflcr_pkg.sv
rtl/mflcr_if.sv
rtl/mflcr_ram.sv
rtl/mono_frame_line_circle_raster.sv
dv/mflcr_tb_if.sv
dv/mono_frame_line_circle_raster_tb.sv
